// ----- sv/rnp_pkg.sv -----
`timescale 1ns / 1ps
package rnp_pkg;

    // Field and datapath widths
    localparam int COORD_W  = 32;
    localparam int DIR_W    = 18;
    localparam int IDX_W    = 10;
    localparam int FRAC_W   = 16;
    localparam int DIFF_W   = COORD_W + 1;          // P - O
    localparam int PROD_W   = DIFF_W + DIR_W;       // diff * dir
    localparam int DOT_W    = PROD_W + 2;           // sum of three products
    localparam int T_W      = 38;                   // ray parameter, Q22.16
    localparam int TP_W     = T_W + DIR_W;          // t * dir
    localparam int RES_W    = 42;                   // residual component
    localparam int ABS_W    = 32;                   // magnitude before saturation
    localparam int SQ_W     = 2 * ABS_W - FRAC_W;   // one square, Q32.16
    localparam int SUM_W    = SQ_W + 2;             // sum of three squares
    localparam int DIST_W   = 32;
    localparam int BEST_W   = 48;
    localparam int DATA_W   = 32;
    localparam int PADDR_W  = 5;
    localparam int LANES    = 3;

    localparam int QUEUE_DEPTH_DEF = 2;

    // Reset values
    localparam logic signed [DIR_W-1:0]  DIR_Z_RESET  = DIR_W'(65536);
    localparam logic [DIST_W-1:0]        RADIUS_RESET = DIST_W'(16384);
    localparam logic signed [BEST_W-1:0] BEST_RESET   = {1'b0, {(BEST_W-1){1'b1}}};
    localparam logic [DIST_W-1:0]        DIST_SAT     = {DIST_W{1'b1}};

    // Register map, word index
    typedef enum logic [2:0] {
        REG_ORIGIN_X  = 3'd0,
        REG_ORIGIN_Y  = 3'd1,
        REG_ORIGIN_Z  = 3'd2,
        REG_DIR_X     = 3'd3,
        REG_DIR_Y     = 3'd4,
        REG_DIR_Z     = 3'd5,
        REG_RADIUS_SQ = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic signed [COORD_W-1:0] origin_z;
        logic signed [DIR_W-1:0]   dir_x;
        logic signed [DIR_W-1:0]   dir_y;
        logic signed [DIR_W-1:0]   dir_z;
        logic [DIST_W-1:0]         radius_sq;
    } cfg_t;

    // One queued request: offset from the origin plus tags
    typedef struct packed {
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic signed [DIFF_W-1:0] dz;
        logic [IDX_W-1:0]         index;
        logic                     last;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ----- sv/ray_nearest_point_pick.sv -----
`timescale 1ns / 1ps
// The back-end sequencer takes one point at a time from the queue and steps it through
// dot product, t, t*dir, residual, square, sum and compare stages before taking the next;
// the last point of a set waits in compare until the result register is free.
// The input side keeps taking points into a short queue while the back end works.
// Reset (aresetn, synchronous, active low) restores register defaults, empties the
// queue, clears the running best hit and drops any pending result.
module ray_nearest_point_pick #(
    parameter int QUEUE_DEPTH = rnp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rnp_pkg::PADDR_W-1:0]        paddr,
    input  logic [rnp_pkg::DATA_W-1:0]         pwdata,
    output logic [rnp_pkg::DATA_W-1:0]         prdata,
    output logic                               pready,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [rnp_pkg::COORD_W-1:0] s_point_x,
    input  logic signed [rnp_pkg::COORD_W-1:0] s_point_y,
    input  logic signed [rnp_pkg::COORD_W-1:0] s_point_z,
    input  logic [rnp_pkg::IDX_W-1:0]          s_point_index,
    input  logic                               s_last_point,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_hit_found,
    output logic [rnp_pkg::IDX_W-1:0]          m_hit_index
);
    import rnp_pkg::*;

    cfg_t    cfg;
    q_stat_t q_stat;
    item_t   push_item;
    item_t   pop_item;
    logic    q_push;
    logic    q_pop;

    rnp_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_point_x     (s_point_x),
        .s_point_y     (s_point_y),
        .s_point_z     (s_point_z),
        .s_point_index (s_point_index),
        .s_last_point  (s_last_point),
        .q_stat        (q_stat),
        .q_push        (q_push),
        .q_item        (push_item),
        .cfg           (cfg)
    );

    rnp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .stat      (q_stat)
    );

    rnp_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .q_stat      (q_stat),
        .q_item      (pop_item),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_hit_found (m_hit_found),
        .m_hit_index (m_hit_index)
    );

endmodule

// ----- sv/rnp_front.sv -----
`timescale 1ns / 1ps
module rnp_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rnp_pkg::PADDR_W-1:0]   paddr,
    input  logic [rnp_pkg::DATA_W-1:0]    pwdata,
    output logic [rnp_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    // point stream
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [rnp_pkg::COORD_W-1:0] s_point_x,
    input  logic signed [rnp_pkg::COORD_W-1:0] s_point_y,
    input  logic signed [rnp_pkg::COORD_W-1:0] s_point_z,
    input  logic [rnp_pkg::IDX_W-1:0]     s_point_index,
    input  logic                          s_last_point,
    // queue side
    input  rnp_pkg::q_stat_t              q_stat,
    output logic                          q_push,
    output rnp_pkg::item_t                q_item,
    output rnp_pkg::cfg_t                 cfg
);
    import rnp_pkg::*;

    cfg_t     cfg_reg, cfg_next;
    reg_idx_t reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

    // register writes; unmapped words are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_ORIGIN_X:  cfg_next.origin_x  = pwdata;
                REG_ORIGIN_Y:  cfg_next.origin_y  = pwdata;
                REG_ORIGIN_Z:  cfg_next.origin_z  = pwdata;
                REG_DIR_X:     cfg_next.dir_x     = pwdata[DIR_W-1:0];
                REG_DIR_Y:     cfg_next.dir_y     = pwdata[DIR_W-1:0];
                REG_DIR_Z:     cfg_next.dir_z     = pwdata[DIR_W-1:0];
                REG_RADIUS_SQ: cfg_next.radius_sq = pwdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.origin_x  <= '0;
            cfg_reg.origin_y  <= '0;
            cfg_reg.origin_z  <= '0;
            cfg_reg.dir_x     <= '0;
            cfg_reg.dir_y     <= '0;
            cfg_reg.dir_z     <= DIR_Z_RESET;
            cfg_reg.radius_sq <= RADIUS_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // read back, direction sign-extended
    always_comb begin
        unique case (reg_idx)
            REG_ORIGIN_X:  prdata = cfg_reg.origin_x;
            REG_ORIGIN_Y:  prdata = cfg_reg.origin_y;
            REG_ORIGIN_Z:  prdata = cfg_reg.origin_z;
            REG_DIR_X:     prdata = DATA_W'(cfg_reg.dir_x);
            REG_DIR_Y:     prdata = DATA_W'(cfg_reg.dir_y);
            REG_DIR_Z:     prdata = DATA_W'(cfg_reg.dir_z);
            REG_RADIUS_SQ: prdata = cfg_reg.radius_sq;
            default:       prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

    // take a point whenever the queue has room, offset it from the origin
    assign s_ready = !q_stat.full;
    assign q_push  = s_valid && s_ready;

    always_comb begin
        q_item.dx    = DIFF_W'(s_point_x) - DIFF_W'(cfg_reg.origin_x);
        q_item.dy    = DIFF_W'(s_point_y) - DIFF_W'(cfg_reg.origin_y);
        q_item.dz    = DIFF_W'(s_point_z) - DIFF_W'(cfg_reg.origin_z);
        q_item.index = s_point_index;
        q_item.last  = s_last_point;
    end

endmodule

// ----- sv/rnp_queue.sv -----
`timescale 1ns / 1ps
module rnp_queue #(
    parameter int DEPTH = rnp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  rnp_pkg::item_t    push_item,
    input  logic              pop,
    output rnp_pkg::item_t    pop_item,
    output rnp_pkg::q_stat_t  stat
);
    import rnp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(DEPTH - 1)) begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign pop_item   = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

// ----- sv/rnp_back.sv -----
`timescale 1ns / 1ps
module rnp_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  rnp_pkg::cfg_t                cfg,
    input  rnp_pkg::q_stat_t             q_stat,
    input  rnp_pkg::item_t               q_item,
    output logic                         q_pop,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_hit_found,
    output logic [rnp_pkg::IDX_W-1:0]    m_hit_index
);
    import rnp_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_DOT  = 8'b0000_0010,
        ST_T    = 8'b0000_0100,
        ST_TD   = 8'b0000_1000,
        ST_RES  = 8'b0001_0000,
        ST_SQ   = 8'b0010_0000,
        ST_SUM  = 8'b0100_0000,
        ST_CMP  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // datapath registers, one request at a time
    item_t                     item_reg;
    logic signed [PROD_W-1:0]  prod_reg [LANES];
    logic signed [T_W-1:0]     t_reg;
    logic signed [TP_W-1:0]    tp_reg   [LANES];
    logic [ABS_W-1:0]          abs_reg  [LANES];
    logic                      sat_reg  [LANES];
    logic [SQ_W-1:0]           sq_reg   [LANES];
    logic [DIST_W-1:0]         d2_reg;

    // set state and result register
    logic signed [BEST_W-1:0]  best_param_reg, best_param_next;
    logic [IDX_W-1:0]          best_index_reg, best_index_next;
    logic                      have_hit_reg, have_hit_next;
    logic                      m_valid_reg, m_valid_next;
    logic                      m_hit_found_reg, m_hit_found_next;
    logic [IDX_W-1:0]          m_hit_index_reg, m_hit_index_next;

    logic signed [DIFF_W-1:0]  diff_arr [LANES];
    logic signed [DIR_W-1:0]   dir_arr  [LANES];
    logic signed [DOT_W-1:0]   dot;
    logic signed [RES_W-1:0]   res      [LANES];
    logic [RES_W-1:0]          res_abs  [LANES];
    logic [2*ABS_W-1:0]        sq_full  [LANES];
    logic [SUM_W-1:0]          sq_sum;
    logic                      take;
    logic                      out_free;
    logic                      upd_have;
    logic [IDX_W-1:0]          upd_index;

    assign diff_arr[0] = item_reg.dx;
    assign diff_arr[1] = item_reg.dy;
    assign diff_arr[2] = item_reg.dz;
    assign dir_arr[0]  = cfg.dir_x;
    assign dir_arr[1]  = cfg.dir_y;
    assign dir_arr[2]  = cfg.dir_z;

    // per-lane arithmetic feeding each stage
    always_comb begin
        dot = DOT_W'(prod_reg[0]) + DOT_W'(prod_reg[1]) + DOT_W'(prod_reg[2]);
        for (int k = 0; k < LANES; k++) begin
            res[k]     = RES_W'(diff_arr[k]) - RES_W'(tp_reg[k] >>> FRAC_W);
            res_abs[k] = res[k][RES_W-1] ? RES_W'(-res[k]) : RES_W'(res[k]);
            sq_full[k] = abs_reg[k] * abs_reg[k];
        end
        sq_sum = SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            item_reg <= q_item;
        end
        for (int k = 0; k < LANES; k++) begin
            if (state_reg == ST_DOT) begin
                prod_reg[k] <= diff_arr[k] * dir_arr[k];
            end
            if (state_reg == ST_TD) begin
                tp_reg[k] <= t_reg * dir_arr[k];
            end
            if (state_reg == ST_RES) begin
                abs_reg[k] <= res_abs[k][ABS_W-1:0];
                sat_reg[k] <= |res_abs[k][RES_W-1:ABS_W];
            end
            if (state_reg == ST_SQ) begin
                sq_reg[k] <= sat_reg[k] ? SQ_W'(DIST_SAT) : sq_full[k][2*ABS_W-1:FRAC_W];
            end
        end
        if (state_reg == ST_T) begin
            t_reg <= T_W'(dot >>> FRAC_W);
        end
        if (state_reg == ST_SUM) begin
            d2_reg <= (sq_sum > SUM_W'(DIST_SAT)) ? DIST_SAT : sq_sum[DIST_W-1:0];
        end
    end

    // candidate test: inside the radius and strictly nearer along the ray
    assign take      = (BEST_W'(t_reg) < best_param_reg) && (d2_reg < cfg.radius_sq);
    assign upd_have  = take || have_hit_reg;
    assign upd_index = take ? item_reg.index : best_index_reg;
    assign out_free  = !m_valid_reg || m_ready;

    // sequencer
    always_comb begin
        state_next       = state_reg;
        q_pop            = 1'b0;
        best_param_next  = best_param_reg;
        best_index_next  = best_index_reg;
        have_hit_next    = have_hit_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_hit_found_next = m_hit_found_reg;
        m_hit_index_next = m_hit_index_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (!q_stat.empty) begin
                    q_pop      = 1'b1;
                    state_next = ST_DOT;
                end
            end
            ST_DOT: state_next = ST_T;
            ST_T:   state_next = ST_TD;
            ST_TD:  state_next = ST_RES;
            ST_RES: state_next = ST_SQ;
            ST_SQ:  state_next = ST_SUM;
            ST_SUM: state_next = ST_CMP;
            ST_CMP: begin
                if (!item_reg.last) begin
                    if (take) begin
                        best_param_next = BEST_W'(t_reg);
                        best_index_next = item_reg.index;
                        have_hit_next   = 1'b1;
                    end
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    // end of set: report and start afresh
                    m_valid_next     = 1'b1;
                    m_hit_found_next = upd_have;
                    m_hit_index_next = upd_have ? upd_index : '0;
                    best_param_next  = BEST_RESET;
                    best_index_next  = '0;
                    have_hit_next    = 1'b0;
                    state_next       = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            best_param_reg <= BEST_RESET;
            best_index_reg <= '0;
            have_hit_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            best_param_reg <= best_param_next;
            best_index_reg <= best_index_next;
            have_hit_reg   <= have_hit_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_hit_found_reg <= m_hit_found_next;
        m_hit_index_reg <= m_hit_index_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_hit_found = m_hit_found_reg;
    assign m_hit_index = m_hit_index_reg;

    // a miss always reports index zero
    a_miss_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_hit_found_reg |-> m_hit_index_reg == '0)
        else $error("miss reported with nonzero index");

    // a held hit always has a real ray parameter
    a_hit_param: assert property (@(posedge aclk) disable iff (!aresetn)
        have_hit_reg |-> best_param_reg != BEST_RESET)
        else $error("hit held without a ray parameter");

    // closing a set posts the result and clears the set state
    a_set_close: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CMP && item_reg.last && out_free
        |=> m_valid_reg && !have_hit_reg && best_param_reg == BEST_RESET)
        else $error("set not closed after last point");

endmodule
